@@ rtl/qrs_pkg.sv @@
package qrs_pkg;

   localparam int QRS_FRAC_BITS  = 16;
   localparam int QRS_COEF_BOUND = 100;
   localparam int COEF_W         = 8;
   localparam int DISC_W         = 18;
   localparam int DISC_PAIRS     = DISC_W / 2;
   localparam int DVS_W          = 10;
   localparam int ROOT_W         = 25;

   typedef enum logic [2:0] {
      ST_TWO    = 3'd0,
      ST_DOUBLE = 3'd1,
      ST_NONE   = 3'd2,
      ST_RANGE  = 3'd3,
      ST_AZERO  = 3'd4
   } status_type;

   typedef struct packed {
      logic                      valid;
      status_type                status;
      logic signed [COEF_W-1:0]  a;
      logic signed [COEF_W-1:0]  b;
   } sqrt_ctl_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic              neg_lo;
      logic              neg_hi;
      logic [DVS_W-1:0]  dvs;
   } div_ctl_type;

endpackage

@@ rtl/quadratic_root_solver_top.sv @@
// quadratic root solver: real roots of a*x^2 + b*x + c in signed fixed point
// input: a transfer happens on a clock edge with start high and busy low;
//   req_coef_a/b/c are 8-bit two's complement coefficients
// busy is always low, so a new triple can be taken every cycle
// output: rsp_valid marks one cycle holding rsp_status, rsp_root_low and
//   rsp_root_high; the receiver takes it at that edge and cannot stall
// pipeline: FRAC_BITS + 9 square root cells, FRAC_BITS + 12 divider cells
//   and four register stages: input, square root entry, divider entry, output
// throughput: one triple per cycle, set by the square root and divider
//   cell chains which each retire one bit per cell
// reset clears all valid flags in the chains; no result leaves afterward
//   until a new triple has gone through
// status: two roots, double root, no real roots, out of range, a zero;
//   roots are zero unless real roots exist, and saturate to 25 bits
module quadratic_root_solver_top #(
   parameter int FRAC_BITS  = qrs_pkg::QRS_FRAC_BITS,
   parameter int COEF_BOUND = qrs_pkg::QRS_COEF_BOUND
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [qrs_pkg::COEF_W-1:0]    req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]    req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]    req_coef_c,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_status,
   output logic signed [qrs_pkg::ROOT_W-1:0]    rsp_root_low,
   output logic signed [qrs_pkg::ROOT_W-1:0]    rsp_root_high
);
   import qrs_pkg::*;

   localparam int SW = DISC_PAIRS + FRAC_BITS;
   localparam int RW = SW + 2;
   localparam int NW = FRAC_BITS + 11;
   localparam int QW = FRAC_BITS + 12;
   localparam int VW = QW + ROOT_W;
   localparam logic signed [16:0] BOUND = 17'(COEF_BOUND);
   localparam logic signed [VW-1:0] RMAX = VW'((64'sd1 <<< (ROOT_W-1)) - 64'sd1);
   localparam logic signed [VW-1:0] RMIN = -VW'(64'sd1 <<< (ROOT_W-1));

   // input register
   logic                      in_vld_ff;
   logic signed [COEF_W-1:0]  a_ff, b_ff, c_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= req_coef_a;
      b_ff <= req_coef_b;
      c_ff <= req_coef_c;
   end

   // range check and discriminant
   sqrt_ctl_type       ctl0_in;
   logic [DISC_W-1:0]  disc0_in;
   logic signed [15:0] bb, ac;
   logic signed [19:0] disc_s;
   logic signed [16:0] ax, bx, cx;
   logic               oor;

   always_comb begin
      ax     = 17'(a_ff);
      bx     = 17'(b_ff);
      cx     = 17'(c_ff);
      oor    = (ax > BOUND) || (ax < -BOUND) || (bx > BOUND) || (bx < -BOUND) ||
               (cx > BOUND) || (cx < -BOUND);
      bb     = 16'(b_ff) * 16'(b_ff);
      ac     = 16'(a_ff) * 16'(c_ff);
      disc_s = 20'(bb) - (20'(ac) <<< 2);
      ctl0_in.valid = in_vld_ff;
      ctl0_in.a     = a_ff;
      ctl0_in.b     = b_ff;
      disc0_in      = DISC_W'(disc_s);
      priority if (oor) begin
         ctl0_in.status = ST_RANGE;
      end else if (a_ff == '0) begin
         ctl0_in.status = ST_AZERO;
      end else if (disc_s < 0) begin
         ctl0_in.status = ST_NONE;
      end else if (disc_s == 0) begin
         ctl0_in.status = ST_DOUBLE;
      end else begin
         ctl0_in.status = ST_TWO;
      end
      if (disc_s < 0) begin
         disc0_in = '0;
      end
   end

   sqrt_ctl_type       sq_ctl  [0:SW];
   logic [RW-1:0]      sq_rem  [0:SW];
   logic [SW-1:0]      sq_root [0:SW];
   logic [DISC_W-1:0]  sq_disc [0:SW];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl[0] <= '0;
      end else begin
         sq_ctl[0] <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_disc[0] <= disc0_in;
   end

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   // square root chain, one root bit per cell
   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SW(SW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_ctl  (sq_ctl[i]),
         .up_rem  (sq_rem[i]),
         .up_root (sq_root[i]),
         .up_disc (sq_disc[i]),
         .dn_ctl  (sq_ctl[i+1]),
         .dn_rem  (sq_rem[i+1]),
         .dn_root (sq_root[i+1]),
         .dn_disc (sq_disc[i+1])
      );
   end

   // numerators, magnitudes and signs for the rounded division
   div_ctl_type         dv0_in;
   logic [QW-1:0]       num_lo_in, num_hi_in;
   logic signed [NW-1:0] nb, s_x, n_lo, n_hi, mag_lo, mag_hi;
   logic [COEF_W-1:0]   abs_a;
   sqrt_ctl_type        sc;

   always_comb begin
      sc     = sq_ctl[SW];
      nb     = -(NW'(sc.b) <<< FRAC_BITS);
      s_x    = NW'({1'b0, sq_root[SW]});
      n_lo   = nb - s_x;
      n_hi   = nb + s_x;
      mag_lo = n_lo[NW-1] ? -n_lo : n_lo;
      mag_hi = n_hi[NW-1] ? -n_hi : n_hi;
      abs_a  = sc.a[COEF_W-1] ? COEF_W'(-sc.a) : COEF_W'(sc.a);
      num_lo_in = (QW'(mag_lo) << 1) + QW'({abs_a, 1'b0});
      num_hi_in = (QW'(mag_hi) << 1) + QW'({abs_a, 1'b0});
      dv0_in.valid  = sc.valid;
      dv0_in.status = sc.status;
      dv0_in.neg_lo = n_lo[NW-1] ^ sc.a[COEF_W-1];
      dv0_in.neg_hi = n_hi[NW-1] ^ sc.a[COEF_W-1];
      dv0_in.dvs    = {abs_a, 2'b00};
   end

   div_ctl_type       dv_ctl    [0:QW];
   logic [QW-1:0]     dv_num_lo [0:QW];
   logic [QW-1:0]     dv_num_hi [0:QW];
   logic [DVS_W-1:0]  dv_rem_lo [0:QW];
   logic [DVS_W-1:0]  dv_rem_hi [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ctl[0] <= '0;
      end else begin
         dv_ctl[0] <= dv0_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_num_lo[0] <= num_lo_in;
      dv_num_hi[0] <= num_hi_in;
   end

   assign dv_rem_lo[0] = '0;
   assign dv_rem_hi[0] = '0;

   // divider chain, one quotient bit per cell
   for (genvar j = 0; j < QW; j++) begin : g_div
      qrs_div_cell #(.QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_ctl    (dv_ctl[j]),
         .up_num_lo (dv_num_lo[j]),
         .up_num_hi (dv_num_hi[j]),
         .up_rem_lo (dv_rem_lo[j]),
         .up_rem_hi (dv_rem_hi[j]),
         .dn_ctl    (dv_ctl[j+1]),
         .dn_num_lo (dv_num_lo[j+1]),
         .dn_num_hi (dv_num_hi[j+1]),
         .dn_rem_lo (dv_rem_lo[j+1]),
         .dn_rem_hi (dv_rem_hi[j+1])
      );
   end

   // sign, saturation and ordering
   div_ctl_type             dc;
   logic signed [VW-1:0]    v_lo, v_hi;
   logic signed [ROOT_W-1:0] r_lo, r_hi;
   logic signed [ROOT_W-1:0] low_in, high_in;
   logic                    vld_ff;
   logic [2:0]              status_ff;
   logic signed [ROOT_W-1:0] low_ff, high_ff;

   always_comb begin
      dc   = dv_ctl[QW];
      v_lo = VW'({1'b0, dv_num_lo[QW]});
      v_hi = VW'({1'b0, dv_num_hi[QW]});
      if (dc.neg_lo) begin
         v_lo = -v_lo;
      end
      if (dc.neg_hi) begin
         v_hi = -v_hi;
      end
      r_lo = (v_lo > RMAX) ? ROOT_W'(RMAX) : (v_lo < RMIN) ? ROOT_W'(RMIN) : ROOT_W'(v_lo);
      r_hi = (v_hi > RMAX) ? ROOT_W'(RMAX) : (v_hi < RMIN) ? ROOT_W'(RMIN) : ROOT_W'(v_hi);
      if (dc.status == ST_TWO || dc.status == ST_DOUBLE) begin
         low_in  = (r_lo < r_hi) ? r_lo : r_hi;
         high_in = (r_lo < r_hi) ? r_hi : r_lo;
      end else begin
         low_in  = '0;
         high_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= dc.valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= dc.status;
      low_ff    <= low_in;
      high_ff   <= high_in;
   end

   assign rsp_valid     = vld_ff;
   assign rsp_status    = status_ff;
   assign rsp_root_low  = low_ff;
   assign rsp_root_high = high_ff;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'(ST_AZERO)))
      else $error("status code out of range");

   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != 3'(ST_TWO) && rsp_status != 3'(ST_DOUBLE))
         |-> (rsp_root_low == '0 && rsp_root_high == '0))
      else $error("roots not cleared without real roots");

   a_double_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == 3'(ST_DOUBLE)) |-> (rsp_root_low == rsp_root_high))
      else $error("double root fields differ");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_root_low <= rsp_root_high))
      else $error("roots out of order");

endmodule

@@ rtl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell #(
   parameter int SW = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qrs_pkg::sqrt_ctl_type         up_ctl,
   input  logic [SW+1:0]                 up_rem,
   input  logic [SW-1:0]                 up_root,
   input  logic [qrs_pkg::DISC_W-1:0]    up_disc,
   output qrs_pkg::sqrt_ctl_type         dn_ctl,
   output logic [SW+1:0]                 dn_rem,
   output logic [SW-1:0]                 dn_root,
   output logic [qrs_pkg::DISC_W-1:0]    dn_disc
);
   import qrs_pkg::*;

   sqrt_ctl_type       ctl_ff;
   logic [SW+1:0]      rem_ff, rem_in;
   logic [SW-1:0]      root_ff, root_in;
   logic [DISC_W-1:0]  disc_ff, disc_in;
   logic [SW+3:0]      rem_sh;
   logic [SW+3:0]      trial;

   always_comb begin
      rem_sh  = {up_rem, up_disc[DISC_W-1 -: 2]};
      trial   = {2'b00, up_root, 2'b01};
      disc_in = {up_disc[DISC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = (SW+2)'(rem_sh - trial);
         root_in = {up_root[SW-2:0], 1'b1};
      end else begin
         rem_in  = (SW+2)'(rem_sh);
         root_in = {up_root[SW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      disc_ff <= disc_in;
   end

   assign dn_ctl  = ctl_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_disc = disc_ff;

endmodule

@@ rtl/qrs_div_cell.sv @@
module qrs_div_cell #(
   parameter int QW = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qrs_pkg::div_ctl_type       up_ctl,
   input  logic [QW-1:0]              up_num_lo,
   input  logic [QW-1:0]              up_num_hi,
   input  logic [qrs_pkg::DVS_W-1:0]  up_rem_lo,
   input  logic [qrs_pkg::DVS_W-1:0]  up_rem_hi,
   output qrs_pkg::div_ctl_type       dn_ctl,
   output logic [QW-1:0]              dn_num_lo,
   output logic [QW-1:0]              dn_num_hi,
   output logic [qrs_pkg::DVS_W-1:0]  dn_rem_lo,
   output logic [qrs_pkg::DVS_W-1:0]  dn_rem_hi
);
   import qrs_pkg::*;

   div_ctl_type       ctl_ff;
   logic [QW-1:0]     num_lo_ff, num_lo_in, num_hi_ff, num_hi_in;
   logic [DVS_W-1:0]  rem_lo_ff, rem_lo_in, rem_hi_ff, rem_hi_in;
   logic [DVS_W:0]    rs_lo, rs_hi;
   logic              ge_lo, ge_hi;

   always_comb begin
      rs_lo     = {up_rem_lo, up_num_lo[QW-1]};
      rs_hi     = {up_rem_hi, up_num_hi[QW-1]};
      ge_lo     = rs_lo >= {1'b0, up_ctl.dvs};
      ge_hi     = rs_hi >= {1'b0, up_ctl.dvs};
      rem_lo_in = ge_lo ? DVS_W'(rs_lo - {1'b0, up_ctl.dvs}) : DVS_W'(rs_lo);
      rem_hi_in = ge_hi ? DVS_W'(rs_hi - {1'b0, up_ctl.dvs}) : DVS_W'(rs_hi);
      num_lo_in = {up_num_lo[QW-2:0], ge_lo};
      num_hi_in = {up_num_hi[QW-2:0], ge_hi};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      num_lo_ff <= num_lo_in;
      num_hi_ff <= num_hi_in;
      rem_lo_ff <= rem_lo_in;
      rem_hi_ff <= rem_hi_in;
   end

   assign dn_ctl    = ctl_ff;
   assign dn_num_lo = num_lo_ff;
   assign dn_num_hi = num_hi_ff;
   assign dn_rem_lo = rem_lo_ff;
   assign dn_rem_hi = rem_hi_ff;

endmodule

@@ test/quadratic_root_solver_top_tb.sv @@
module quadratic_root_solver_top_tb;
   import qrs_pkg::*;

   localparam int FRAC      = QRS_FRAC_BITS;
   localparam int BOUND     = QRS_COEF_BOUND;
   localparam int LATENCY   = 2 * FRAC + 25;
   localparam int CYCLE_CAP = 400000;
   localparam longint ROOT_HI = (64'sd1 <<< (ROOT_W - 1)) - 1;
   localparam longint ROOT_LO = -(64'sd1 <<< (ROOT_W - 1));

   typedef struct {
      status_type        status;
      logic [ROOT_W-1:0] lo;
      logic [ROOT_W-1:0] hi;
   } roots_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [COEF_W-1:0] req_coef_a = '0;
   logic signed [COEF_W-1:0] req_coef_b = '0;
   logic signed [COEF_W-1:0] req_coef_c = '0;
   logic                     rsp_valid;
   logic [2:0]               rsp_status;
   logic signed [ROOT_W-1:0] rsp_root_low;
   logic signed [ROOT_W-1:0] rsp_root_high;

   roots_type expected_roots[$];
   int        errors = 0;
   int        cycles = 0;
   bit        gaps_on = 1'b1;

   quadratic_root_solver_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_root_low(rsp_root_low), .rsp_root_high(rsp_root_high)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sqrt_scaled(longint d);
      longint rem, root, trial, pair;
      rem = 0;
      root = 0;
      for (int i = 0; i < DISC_PAIRS + FRAC; i++) begin
         pair = (i < DISC_PAIRS) ? ((d >> (2 * (DISC_PAIRS - 1 - i))) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint div_round(longint n, longint d);
      longint un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un * 2 + ud) / (ud * 2);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic longint clamp_root(longint v);
      if (v > ROOT_HI) return ROOT_HI;
      if (v < ROOT_LO) return ROOT_LO;
      return v;
   endfunction

   function automatic roots_type solve_roots(logic signed [COEF_W-1:0] ca,
                                             logic signed [COEF_W-1:0] cb,
                                             logic signed [COEF_W-1:0] cc);
      roots_type r;
      longint a, b, c, disc, s, nb, r1, r2;
      a = longint'(ca);
      b = longint'(cb);
      c = longint'(cc);
      r.lo = '0;
      r.hi = '0;
      if (a < -BOUND || a > BOUND || b < -BOUND || b > BOUND || c < -BOUND || c > BOUND)
         r.status = ST_RANGE;
      else if (a == 0)
         r.status = ST_AZERO;
      else begin
         disc = b * b - 4 * a * c;
         if (disc < 0)
            r.status = ST_NONE;
         else begin
            s = sqrt_scaled(disc);
            nb = -b * (64'sd1 <<< FRAC);
            r1 = clamp_root(div_round(nb - s, 2 * a));
            r2 = clamp_root(div_round(nb + s, 2 * a));
            r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
            r.lo = ROOT_W'((r1 < r2) ? r1 : r2);
            r.hi = ROOT_W'((r1 < r2) ? r2 : r1);
         end
      end
      return r;
   endfunction

   task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                             logic signed [COEF_W-1:0] c);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_roots.push_back(solve_roots(a, b, c));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] coef_in_range();
      return COEF_W'($signed($urandom_range(0, 2 * BOUND)) - BOUND);
   endfunction

   task automatic test_directed();
      send_coefs(1, -3, 2);
      send_coefs(1, 2, 1);
      send_coefs(1, 0, 1);
      send_coefs(0, 5, 3);
      send_coefs(101, 0, 0);
      send_coefs(1, -101, 0);
      send_coefs(1, 0, -128);
      send_coefs(-128, 127, 127);
      send_coefs(100, 100, 100);
      send_coefs(-100, -100, -100);
      send_coefs(1, 100, -100);
      send_coefs(-1, -100, 100);
      send_coefs(1, 0, -100);
      send_coefs(-1, 0, 100);
      send_coefs(1, 0, 0);
      send_coefs(-100, 1, 0);
      send_coefs(2, 4, 2);
      send_coefs(100, -100, 25);
      send_coefs(0, 0, 0);
      send_coefs(-1, -1, -1);
      send_coefs(3, 7, -5);
   endtask

   task automatic test_random(int count);
      logic signed [COEF_W-1:0] a, b, c;
      int kind;
      for (int i = 0; i < count; i++) begin
         a = coef_in_range();
         b = coef_in_range();
         c = coef_in_range();
         kind = $urandom_range(0, 19);
         if (kind == 0) a = COEF_W'($urandom);
         else if (kind == 1) b = COEF_W'($urandom);
         else if (kind == 2) c = COEF_W'($urandom);
         else if (kind == 3) a = 0;
         else if (kind < 7) begin
            a = COEF_W'($signed($urandom_range(1, 10)) * ($urandom_range(0, 1) ? 1 : -1));
            b = COEF_W'(2 * a * ($signed($urandom_range(0, 20)) - 10));
            c = COEF_W'(b * b / (4 * a));
            if (c > BOUND || c < -BOUND) c = 0;
         end
         send_coefs(a, b, c);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      roots_type e;
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            $display("%0t: unexpected transfer status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = expected_roots.pop_front();
            if (rsp_status !== e.status || rsp_root_low !== e.lo || rsp_root_high !== e.hi) begin
               $display("%0t: expected %0d %h %h actual %0d %h %h", $time, e.status, e.lo,
                        e.hi, rsp_status, rsp_root_low, rsp_root_high);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_random(1000);
      wait_drained();
      gaps_on = 1'b0;
      test_random(780);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_roots.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
